### src/lzss_ring_window_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
`ifndef LZSS_RING_WINDOW_DECODER_ASSERT_SVH
`define LZSS_RING_WINDOW_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LRWD_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lrwd_pkg.sv
// Package: constants and result type of the LZSS ring window decoder.
`default_nettype none
package lrwd_pkg;

  localparam int unsigned LRWD_WINDOW_DEF = 4096;
  localparam int unsigned MATCH_MIN       = 3;
  localparam int unsigned MATCH_MAX       = 18;
  localparam int unsigned CFG_AW          = 2;
  localparam int unsigned LEN_W           = 5;

  localparam logic [7:0]        SPACE_CHAR = 8'h20;
  localparam logic [CFG_AW-1:0] ADDR_LIMIT = 2'd0;

  // one result transfer
  typedef struct packed {
    logic [31:0] count;
    logic        fin;
    logic        last;
    logic        valid;
    logic [7:0]  data;
  } lrwd_res_t;

endpackage
`default_nettype wire

### src/lrwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lrwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### src/lzss_ring_window_decoder.sv
// Top level: LZSS decoder with a ring history window, streaming in and out.
// Usage
//  - in_*: one compressed byte per transfer (in_tdata), in_tlast on the final byte.
//  - out_*: one decoded byte or a bare end marker per transfer; tlast marks the
//    last result caused by an input byte, tuser[1] marks end of decoding.
//  - cfg_*: APB-style; register 0 (byte address 0) is the output limit.
//    Write it only while the block is idle.
// Timing
//  - Results are registered: a literal or end marker shows in the cycle after its
//    transfer, the first copied byte of a match after the window read and copy state.
//  - Flag bytes, literals and the first byte of a match are taken with no extra state.
//  - The second byte of a match starts a copy of L bytes (3..18): it issues the
//    first window read, then the copy gives one byte per cycle while the output
//    is free, bounded by the single read port of the window RAM.
// Reset
//  - Clears the parser, counters and end flag; the window RAM is not cleared,
//    only entries written since reset are ever used (earlier positions give spaces).
// Back-pressure
//  - A stalled receiver holds the output register; in_tready drops and a match
//    copy pauses until the register is taken.
`default_nettype none
module lzss_ring_window_decoder
  import lrwd_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = LRWD_WINDOW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,    // [7:0] in_byte
  input  wire logic              in_tlast,
  // output stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [39:0]            out_tdata,   // [7:0] out_byte, [39:8] decoded_count
  output logic [1:0]             out_tuser,   // [0] out_valid, [1] stream_end
  output logic                   out_tlast,
  // configuration
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  `include "lzss_ring_window_decoder_assert.svh"

  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam int unsigned DW = AW + 1;
  localparam int unsigned RING_START = WINDOW_SIZE - MATCH_MAX;

  // sequencer states
  localparam logic ST_IN   = 1'b0;
  localparam logic ST_COPY = 1'b1;

  // parse phases
  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_ITEM = 2'd1;
  localparam logic [1:0] PH_PAIR = 2'd2;

  logic            state_r, state_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [8:0]      flags_r, flags_nxt;
  logic [7:0]      pend_r, pend_nxt;
  logic [31:0]     emitted_r, emitted_nxt;
  logic            finished_r, finished_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [DW-1:0]   dist_r, dist_nxt;
  logic            fwd_r, fwd_nxt;
  logic [7:0]      fwd_data_r, fwd_data_nxt;
  logic [31:0]     limit_r;
  logic            out_tvalid_r, out_tvalid_nxt;
  lrwd_res_t       out_res_r, res_nxt;

  logic            out_free, in_xfer, load_out, cfg_wr;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [7:0]      ram_wdata, ram_rdata;

  logic [8:0]      flags_shift;
  logic [1:0]      phase_after;
  logic [AW-1:0]   here, pos, d_start;
  logic [31:0]     cnt_inc;
  logic            limit_hit, fin_inc, before_start;
  logic [7:0]      win_byte, copy_byte;
  lrwd_res_t       end_res;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr == ADDR_LIMIT) ? limit_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 32'd0;
    end else if (cfg_wr && cfg_paddr == ADDR_LIMIT) begin
      limit_r <= cfg_pwdata;
    end
  end

  // ---------------------------------------------------------------- window
  lrwd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- shared terms
  assign out_free = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == ST_IN) && out_free;
  assign in_xfer   = in_tvalid && in_tready;

  // next flag bit; back to flag byte once only the sentinel is left
  assign flags_shift = {1'b0, flags_r[8:1]};
  assign phase_after = (flags_shift <= 9'd1) ? PH_FLAG : PH_ITEM;

  assign cnt_inc   = emitted_r + 32'd1;
  assign limit_hit = emitted_r >= limit_r;
  assign fin_inc   = cnt_inc >= limit_r;

  // match start: absolute ring position to distance (zero means a full window)
  assign here    = emitted_r[AW-1:0] + AW'(RING_START);
  assign pos     = AW'({in_tdata[7:4], pend_r});
  assign d_start = here - pos;

  // copy byte: forwarded when the source was written in the read cycle
  assign win_byte     = fwd_r ? fwd_data_r : ram_rdata;
  assign before_start = emitted_r < 32'(dist_r);
  assign copy_byte    = before_start ? SPACE_CHAR : win_byte;

  assign end_res = '{count: emitted_r, fin: 1'b1, last: 1'b1, valid: 1'b0, data: 8'd0};

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    flags_nxt    = flags_r;
    pend_nxt     = pend_r;
    emitted_nxt  = emitted_r;
    finished_nxt = finished_r;
    rem_nxt      = rem_r;
    dist_nxt     = dist_r;
    fwd_nxt      = fwd_r;
    fwd_data_nxt = fwd_data_r;
    load_out     = 1'b0;
    res_nxt      = end_res;
    ram_we       = 1'b0;
    ram_waddr    = emitted_r[AW-1:0];
    ram_wdata    = in_tdata;
    ram_re       = 1'b0;
    ram_raddr    = emitted_r[AW-1:0] - d_start;

    case (state_r)
      ST_IN: begin
        if (in_xfer && !finished_r) begin
          case (phase_r)
            PH_ITEM: begin
              if (flags_r[0]) begin
                load_out = 1'b1;
                if (limit_hit) begin
                  finished_nxt = 1'b1;
                end else begin
                  ram_we       = 1'b1;
                  emitted_nxt  = cnt_inc;
                  finished_nxt = fin_inc | in_tlast;
                  res_nxt      = '{count: cnt_inc, fin: fin_inc | in_tlast, last: 1'b1,
                                   valid: 1'b1, data: in_tdata};
                  flags_nxt    = flags_shift;
                  phase_nxt    = phase_after;
                end
              end else begin
                pend_nxt  = in_tdata;
                phase_nxt = PH_PAIR;
                if (in_tlast) begin
                  load_out     = 1'b1;
                  finished_nxt = 1'b1;
                end
              end
            end
            PH_PAIR: begin
              if (in_tlast) begin
                load_out     = 1'b1;
                finished_nxt = 1'b1;
              end else begin
                // first window read goes out with the transfer
                ram_re    = 1'b1;
                fwd_nxt   = 1'b0;
                dist_nxt  = (d_start == '0) ? DW'(WINDOW_SIZE) : {1'b0, d_start};
                rem_nxt   = LEN_W'(in_tdata[3:0]) + LEN_W'(MATCH_MIN);
                state_nxt = ST_COPY;
              end
            end
            default: begin
              flags_nxt = {1'b1, in_tdata};
              phase_nxt = PH_ITEM;
              if (in_tlast) begin
                load_out     = 1'b1;
                finished_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      ST_COPY: begin
        if (out_free) begin
          load_out = 1'b1;
          if (limit_hit) begin
            finished_nxt = 1'b1;
            flags_nxt    = flags_shift;
            phase_nxt    = phase_after;
            state_nxt    = ST_IN;
          end else begin
            ram_we       = 1'b1;
            ram_wdata    = copy_byte;
            emitted_nxt  = cnt_inc;
            finished_nxt = fin_inc;
            res_nxt      = '{count: cnt_inc, fin: fin_inc, last: fin_inc || rem_r == 1,
                             valid: 1'b1, data: copy_byte};
            if (fin_inc || rem_r == 1) begin
              flags_nxt = flags_shift;
              phase_nxt = phase_after;
              state_nxt = ST_IN;
            end else begin
              // read for the following byte; distance one hits this write
              rem_nxt      = rem_r - 1'b1;
              ram_re       = 1'b1;
              ram_raddr    = cnt_inc[AW-1:0] - dist_r[AW-1:0];
              fwd_nxt      = (ram_raddr == emitted_r[AW-1:0]);
              fwd_data_nxt = copy_byte;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IN;
      end
    endcase

    out_tvalid_nxt = load_out | (out_tvalid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IN;
      phase_r      <= PH_FLAG;
      flags_r      <= 9'd0;
      pend_r       <= 8'd0;
      emitted_r    <= 32'd0;
      finished_r   <= 1'b0;
      rem_r        <= '0;
      fwd_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      flags_r      <= flags_nxt;
      pend_r       <= pend_nxt;
      emitted_r    <= emitted_nxt;
      finished_r   <= finished_nxt;
      rem_r        <= rem_nxt;
      fwd_r        <= fwd_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    fwd_data_r <= fwd_data_nxt;
    if (load_out) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_res_r.count, out_res_r.data};
  assign out_tuser  = {out_res_r.fin, out_res_r.valid};
  assign out_tlast  = out_res_r.last;

  // ---------------------------------------------------------------- checks
  `LRWD_ASSERT_HOLDS(a_copy_rem, clk, rst_n, state_r == ST_COPY, rem_r != '0, "copy with no bytes left")
  `LRWD_ASSERT_HOLDS(a_fwd_dist, clk, rst_n, fwd_r, dist_r == DW'(1), "forward without distance one")
  `LRWD_ASSERT_NEXT(a_fin_sticky, clk, rst_n, finished_r, finished_r, "end flag cleared")
  `LRWD_ASSERT_HOLDS(a_end_fin, clk, rst_n, out_tvalid && out_tuser[1], finished_r, "end result while running")
  `LRWD_ASSERT_NEXT(a_count_step, clk, rst_n, load_out && res_nxt.valid, emitted_r == $past(emitted_r) + 32'd1, "count step")

endmodule
`default_nettype wire
